>>> rtl/core/lmsh_pkg.sv
// lmsh_pkg: shared types, request codes and the linear transform function
// for the streaming mix hash block
// no dependencies
`timescale 1ns / 1ps

package lmsh_pkg;

  localparam int STATE_W  = 128;
  localparam int WORD_W   = 32;
  localparam int HALF_W   = 64;
  localparam int POS_W    = 4;
  localparam int BYTE_W   = 8;
  localparam int REQ_W    = 2;

  // request type codes
  localparam logic [REQ_W-1:0] REQ_ABSORB     = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ABSORB_FIN = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FINISH     = 2'd2;

  localparam logic [STATE_W-1:0] STATE_INIT = {STATE_W{1'b1}};
  localparam logic [POS_W-1:0]   POS_LAST   = {POS_W{1'b1}};

  // result of one transaction through the datapath
  typedef struct packed {
    logic [STATE_W-1:0] state_nxt;
    logic [POS_W-1:0]   pos_nxt;
    logic [STATE_W-1:0] digest;
    logic               emit;
  } mix_res_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                             input int unsigned r);
    rotl = (x << r) | (x >> (WORD_W - r));
  endfunction

  // serpent-style linear transform over four words, word 0 in the low bits
  function automatic logic [STATE_W-1:0] linear_mix(input logic [STATE_W-1:0] s);
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] d;
    a = s[31:0];
    b = s[63:32];
    c = s[95:64];
    d = s[127:96];
    a = rotl(a, 13);
    c = rotl(c, 3);
    b = b ^ a ^ c;
    d = d ^ c ^ (a << 3);
    b = rotl(b, 1);
    d = rotl(d, 7);
    a = a ^ b ^ d;
    c = c ^ d ^ (b << 7);
    a = rotl(a, 5);
    c = rotl(c, 22);
    linear_mix = {d, c, b, a};
  endfunction

endpackage

>>> rtl/core/lmsh_mix.sv
// lmsh_mix: combinational datapath for one transaction: byte absorb,
// block transform and finish (invert and transform)
// depends on lmsh_pkg
`timescale 1ns / 1ps

module lmsh_mix import lmsh_pkg::*; (
  input  logic [STATE_W-1:0] state,
  input  logic [POS_W-1:0]   pos,
  input  logic [REQ_W-1:0]   req_type,
  input  logic [BYTE_W-1:0]  data_byte,
  output mix_res_t           res
);

  logic [STATE_W-1:0] byte_vec;
  logic [STATE_W-1:0] xored;
  logic [STATE_W-1:0] absorbed;
  logic [POS_W-1:0]   pos_inc;
  logic [STATE_W-1:0] fin_src;
  logic [STATE_W-1:0] fin_digest;

  // place the byte at state byte pos, little-endian within words
  assign byte_vec = {{(STATE_W-BYTE_W){1'b0}}, data_byte} << {pos, 3'b000};
  assign xored    = state ^ byte_vec;
  assign absorbed = (pos == POS_LAST) ? linear_mix(xored) : xored;
  assign pos_inc  = pos + 1'b1;

  // finish path works from the absorbed state or the current one
  assign fin_src    = (req_type == REQ_FINISH) ? state : absorbed;
  assign fin_digest = linear_mix(~fin_src);

  // request decode
  always_comb begin
    res.state_nxt = state;
    res.pos_nxt   = pos;
    res.digest    = fin_digest;
    res.emit      = 1'b0;
    case (req_type)
      REQ_ABSORB: begin
        res.state_nxt = absorbed;
        res.pos_nxt   = pos_inc;
      end
      REQ_ABSORB_FIN, REQ_FINISH: begin
        res.state_nxt = STATE_INIT;
        res.pos_nxt   = '0;
        res.emit      = 1'b1;
      end
      default: begin
        res.state_nxt = state;
        res.pos_nxt   = pos;
      end
    endcase
  end

endmodule

>>> rtl/core/lmsh_outbuf.sv
// lmsh_outbuf: result register holding one digest and sending it as two
// 64-bit halves over a valid/ready channel
// depends on lmsh_pkg
`timescale 1ns / 1ps

module lmsh_outbuf import lmsh_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  logic [STATE_W-1:0] digest,
  output logic               can_load,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [HALF_W-1:0]  out_digest_half,
  output logic               out_half_index,
  output logic               out_last_half
);

  logic [STATE_W-1:0] digest_r;
  logic [1:0]         pend_r;
  logic [1:0]         pend_nxt;
  logic               take;

  assign out_valid = (pend_r != 2'd0);
  assign take      = out_valid && out_ready;
  // room for a new digest once the last half leaves this cycle
  assign can_load  = (pend_r == 2'd0) || ((pend_r == 2'd1) && out_ready);

  // pending half count
  always_comb begin
    pend_nxt = pend_r;
    if (load) begin
      pend_nxt = 2'd2;
    end else if (take) begin
      pend_nxt = pend_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // digest payload
  always_ff @(posedge clk) begin
    if (load) begin
      digest_r <= digest;
    end
  end

  // half select
  assign out_half_index  = (pend_r == 2'd1);
  assign out_last_half   = out_half_index;
  assign out_digest_half = out_half_index ? digest_r[STATE_W-1:HALF_W]
                                          : digest_r[HALF_W-1:0];

`ifndef SYNTHESIS
  a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("outbuf pending count out of range");
  a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> can_load)
    else $error("digest loaded while halves still pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_digest_half)
                                  && $stable(out_half_index))
    else $error("out transaction changed while waiting");
`endif

endmodule

>>> rtl/core/lt_mix_stream_hash_unit.sv
// lt_mix_stream_hash_unit: top level of the streaming 128-bit mix hash
// depends on lmsh_pkg, lmsh_mix, lmsh_outbuf
//
//   channel | ports                                      | direction
//   --------+--------------------------------------------+----------
//   in      | in_valid in_ready in_req_type in_data_byte  | to block
//   out     | out_valid out_ready out_digest_half          | from block
//           | out_half_index out_last_half                 |
//
// one input transaction per cycle unless a finish stalls; the hash
// state takes one absorb step and at most one transform on acceptance
// a finish shows two halves from the next cycle on, one per ready cycle
// reset sets the state to all ones and the byte position to zero
// absorb-only transactions flow through while a digest waits; a finish
// stalls only while the previous digest still has halves to send
`timescale 1ns / 1ps

module lt_mix_stream_hash_unit import lmsh_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [BYTE_W-1:0] in_data_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [HALF_W-1:0] out_digest_half,
  output logic              out_half_index,
  output logic              out_last_half
);

  logic [STATE_W-1:0] state_r;
  logic [POS_W-1:0]   pos_r;
  mix_res_t           res;
  logic               can_load;
  logic               accept;
  logic               load;
  logic               is_fin;

  assign is_fin   = (in_req_type == REQ_ABSORB_FIN) || (in_req_type == REQ_FINISH);
  assign in_ready = is_fin ? can_load : 1'b1;
  assign accept   = in_valid && in_ready;
  assign load     = accept && res.emit;

  // datapath
  lmsh_mix u_mix (
    .state     (state_r),
    .pos       (pos_r),
    .req_type  (in_req_type),
    .data_byte (in_data_byte),
    .res       (res)
  );

  // hash state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_INIT;
      pos_r   <= '0;
    end else if (accept) begin
      state_r <= res.state_nxt;
      pos_r   <= res.pos_nxt;
    end
  end

  // result register
  lmsh_outbuf u_outbuf (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (load),
    .digest          (res.digest),
    .can_load        (can_load),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_half (out_digest_half),
    .out_half_index  (out_half_index),
    .out_last_half   (out_last_half)
  );

`ifndef SYNTHESIS
  a_fin_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_fin) |=> (state_r == STATE_INIT) && (pos_r == '0))
    else $error("state not restarted after finish transaction");
  a_fin_first_half: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_fin) |=> out_valid && !out_half_index)
    else $error("first digest half not presented after finish");
  a_absorb_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_req_type == REQ_ABSORB)) |=> pos_r == $past(pos_r) + 1'b1)
    else $error("byte position did not advance on absorb");
`endif

endmodule

>>> tb/lt_mix_stream_hash_unit_tb.sv
// lt_mix_stream_hash_unit_tb: self-checking testbench for the streaming mix hash block
// depends on lmsh_pkg and lt_mix_stream_hash_unit; predicts each digest half
// with its own state copy and checks every out transaction against it
`timescale 1ns / 1ps

module lt_mix_stream_hash_unit_tb;
  import lmsh_pkg::*;

  // unused request code, accepted and ignored by the block
  localparam logic [REQ_W-1:0] REQ_IGNORED = 2'd3;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [HALF_W-1:0] half;
    logic              idx;
    logic              last;
  } digest_half_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [REQ_W-1:0]  in_req_type = REQ_ABSORB;
  logic [BYTE_W-1:0] in_data_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [HALF_W-1:0] out_digest_half;
  logic              out_half_index;
  logic              out_last_half;

  // predicted hash state and pending digest halves
  logic [STATE_W-1:0] hash_state = STATE_INIT;
  logic [POS_W-1:0]   hash_pos = '0;
  digest_half_t       digest_q[$];

  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;

  lt_mix_stream_hash_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_half (out_digest_half),
    .out_half_index  (out_half_index),
    .out_last_half   (out_last_half)
  );

  always #5 clk = ~clk;

  // rotate left through a doubled word
  function automatic logic [WORD_W-1:0] rol32(logic [WORD_W-1:0] v, int unsigned n);
    logic [2*WORD_W-1:0] t;
    t = {v, v} << n;
    return t[2*WORD_W-1:WORD_W];
  endfunction

  // four-word linear diffusion, word 0 in the low bits
  function automatic logic [STATE_W-1:0] diffuse(logic [STATE_W-1:0] s);
    logic [WORD_W-1:0] w0;
    logic [WORD_W-1:0] w1;
    logic [WORD_W-1:0] w2;
    logic [WORD_W-1:0] w3;
    {w3, w2, w1, w0} = s;
    w0 = rol32(w0, 13);
    w2 = rol32(w2, 3);
    w1 = w1 ^ w0 ^ w2;
    w3 = w3 ^ w2 ^ (w0 << 3);
    w1 = rol32(w1, 1);
    w3 = rol32(w3, 7);
    w0 = w0 ^ w1 ^ w3;
    w2 = w2 ^ w3 ^ (w1 << 7);
    w0 = rol32(w0, 5);
    w2 = rol32(w2, 22);
    return {w3, w2, w1, w0};
  endfunction

  // update the predicted state for one accepted transaction
  task automatic predict_digest(logic [REQ_W-1:0] req, logic [BYTE_W-1:0] data);
    digest_half_t h;
    if (req == REQ_IGNORED) return;
    if (req != REQ_FINISH) begin
      hash_state[hash_pos*8 +: 8] ^= data;
      if (hash_pos == POS_LAST) hash_state = diffuse(hash_state);
      hash_pos = hash_pos + 1'b1;
    end
    if (req == REQ_ABSORB) return;
    hash_state = diffuse(~hash_state);
    h.half = hash_state[HALF_W-1:0];
    h.idx  = 1'b0;
    h.last = 1'b0;
    digest_q.push_back(h);
    h.half = hash_state[STATE_W-1:HALF_W];
    h.idx  = 1'b1;
    h.last = 1'b1;
    digest_q.push_back(h);
    hash_state = STATE_INIT;
    hash_pos   = '0;
  endtask

  // offer one transaction, called at a rising edge, returns at its acceptance edge
  task automatic send_item(logic [REQ_W-1:0] req, logic [BYTE_W-1:0] data);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_data_byte <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_digest(req, data);
  endtask

  // one message of len bytes, closed by a finish
  task automatic send_message(int len);
    bit fin_on_byte;
    fin_on_byte = (len > 0) && $urandom_range(1);
    for (int i = 0; i < len - 1; i++) send_item(REQ_ABSORB, 8'($urandom));
    if (len > 0) send_item(fin_on_byte ? REQ_ABSORB_FIN : REQ_ABSORB, 8'($urandom));
    if (!fin_on_byte) send_item(REQ_FINISH, 8'($urandom));
  endtask

  // stop offering and wait for every pending digest half
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (digest_q.size() != 0);
  endtask

  // extremes, empty message, partial and full block, an ignored code
  task automatic test_directed();
    send_item(REQ_FINISH, 8'h00);
    send_item(REQ_ABSORB, 8'hff);
    send_item(REQ_ABSORB, 8'h00);
    send_item(REQ_ABSORB_FIN, 8'haa);
    send_item(REQ_IGNORED, 8'h5a);
    send_item(REQ_FINISH, 8'h77);
    for (int i = 0; i < 15; i++) send_item(REQ_ABSORB, 8'(i * 17));
    send_item(REQ_ABSORB_FIN, 8'hff);
    send_item(REQ_ABSORB_FIN, 8'h80);
    wait_drain();
  endtask

  // mostly well-formed messages with random bytes, some stray transactions
  task automatic test_random_stream(int n_items, int s_pct, int r_pct);
    int start;
    int len;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    start = 0;
    while (start < n_items) begin
      if ($urandom_range(99) < 10) begin
        send_item(2'($urandom_range(3)), 8'($urandom));
        start++;
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(80) : $urandom_range(20);
        send_message(len);
        start += len + 1;
      end
    end
    wait_drain();
  endtask

  // long receiver hold while short messages keep coming
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = HOLD_CYCLES;
    for (int i = 0; i < 30; i++) send_message($urandom_range(2));
    wait_drain();
  endtask

  // receiver ready, with an optional hold counted here
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each out transaction with the oldest predicted half
  always @(posedge clk) begin : check_results
    digest_half_t want;
    if (rst_n && out_valid && out_ready) begin
      if (digest_q.size() == 0) begin
        $error("unexpected transaction: digest_half %h half_index %0d last_half %0d",
               out_digest_half, out_half_index, out_last_half);
        fail_count++;
      end else begin
        want = digest_q.pop_front();
        if (out_digest_half !== want.half) begin
          $error("digest_half: expected %h, actual %h", want.half, out_digest_half);
          fail_count++;
        end
        if (out_half_index !== want.idx) begin
          $error("half_index: expected %0d, actual %0d", want.idx, out_half_index);
          fail_count++;
        end
        if (out_last_half !== want.last) begin
          $error("last_half: expected %0d, actual %0d", want.last, out_last_half);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_stream(470, 21, 68);
    test_backpressure();
    test_random_stream(470, 68, 21);
    test_random_stream(470, 0, 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && digest_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
